// File: rtl/jepd_pkg.sv
package jepd_pkg;

    // default width of the tick counter
    localparam int TICK_COUNTER_BITS_DEF = 16;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_ECU_ADDR  = 2'd0;
    localparam logic [1:0] CFG_CONV_ADDR = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd2;
    localparam logic [1:0] CFG_LINK_EN   = 2'd3;

    // configuration reset values
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // identifier fields
    localparam logic [28:0] PGN_MASK = 29'h00FFFF00;
    localparam logic [28:0] SRC_MASK = 29'h000000FF;

    // decoded parameter groups
    localparam logic [15:0] PGN_EEC2  = 16'hF003;
    localparam logic [15:0] PGN_EEC1  = 16'hF004;
    localparam logic [15:0] PGN_ET1   = 16'hFEEE;
    localparam logic [15:0] PGN_EFLP1 = 16'hFEEF;
    localparam logic [15:0] PGN_LFE   = 16'hFEF2;
    localparam logic [15:0] PGN_IC1   = 16'hFEF6;

    // parameter codes on the output
    localparam logic [3:0] CODE_NONE         = 4'd0;
    localparam logic [3:0] CODE_LOAD         = 4'd1;
    localparam logic [3:0] CODE_SPEED        = 4'd2;
    localparam logic [3:0] CODE_COOLANT      = 4'd3;
    localparam logic [3:0] CODE_FUEL_TEMP    = 4'd4;
    localparam logic [3:0] CODE_OIL_TEMP     = 4'd5;
    localparam logic [3:0] CODE_OIL_PRESS    = 4'd6;
    localparam logic [3:0] CODE_FUEL_RATE    = 4'd7;
    localparam logic [3:0] CODE_EXHAUST      = 4'd8;
    localparam logic [3:0] CODE_INTAKE_PRESS = 4'd9;
    localparam logic [3:0] CODE_INTAKE_TEMP  = 4'd10;

    // scaling offsets: 40 degC, and 273 K at 1/32 degC
    localparam logic signed [16:0] CELSIUS_OFS  = 17'sd40;
    localparam logic signed [16:0] KELVIN32_OFS = 17'sd8736;

    // frame class decided by the front end
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_EEC2,
        KIND_EEC1,
        KIND_ET1,
        KIND_EFLP1,
        KIND_LFE,
        KIND_IC1
    } kind_t;

    // one queued transaction
    typedef struct packed {
        kind_t      kind;
        logic       connected;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
    } entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // one output record
    typedef struct packed {
        logic [3:0]        code;
        logic signed [16:0] value;
    } record_t;

    // index of the final record of a class
    function automatic logic [1:0] last_index(input kind_t kind);
        logic [1:0] n;
        unique case (kind)
            KIND_ET1, KIND_IC1: n = 2'd2;
            default:            n = 2'd0;
        endcase
        return n;
    endfunction

    // byte minus 40
    function automatic logic signed [16:0] celsius(input logic [7:0] b);
        logic signed [16:0] t;
        t = $signed({9'b0, b}) - CELSIUS_OFS;
        return t;
    endfunction

    // 16-bit word at 1/32 K minus 273 K
    function automatic logic signed [16:0] kelvin32(input logic [7:0] lo, input logic [7:0] hi);
        logic signed [16:0] t;
        t = $signed({1'b0, hi, lo}) - KELVIN32_OFS;
        return t;
    endfunction

    // scaled record for one position of a class
    function automatic record_t make_record(input entry_t e, input logic [1:0] idx);
        record_t r;
        r.code  = CODE_NONE;
        r.value = '0;
        unique case (e.kind)
            KIND_EEC2:
            begin
                r.code  = CODE_LOAD;
                r.value = $signed({9'b0, e.b2});
            end
            KIND_EEC1:
            begin
                r.code  = CODE_SPEED;
                r.value = $signed({1'b0, e.b4, e.b3});
            end
            KIND_ET1:
            begin
                unique case (idx)
                    2'd0:
                    begin
                        r.code  = CODE_COOLANT;
                        r.value = celsius(e.b0);
                    end
                    2'd1:
                    begin
                        r.code  = CODE_FUEL_TEMP;
                        r.value = celsius(e.b1);
                    end
                    default:
                    begin
                        r.code  = CODE_OIL_TEMP;
                        r.value = kelvin32(e.b2, e.b3);
                    end
                endcase
            end
            KIND_EFLP1:
            begin
                r.code  = CODE_OIL_PRESS;
                r.value = $signed({7'b0, e.b3, 2'b00});
            end
            KIND_LFE:
            begin
                r.code  = CODE_FUEL_RATE;
                r.value = $signed({1'b0, e.b1, e.b0});
            end
            KIND_IC1:
            begin
                unique case (idx)
                    2'd0:
                    begin
                        r.code  = CODE_EXHAUST;
                        r.value = kelvin32(e.b5, e.b6);
                    end
                    2'd1:
                    begin
                        r.code  = CODE_INTAKE_PRESS;
                        r.value = $signed({9'b0, e.b0});
                    end
                    default:
                    begin
                        r.code  = CODE_INTAKE_TEMP;
                        r.value = celsius(e.b2);
                    end
                endcase
            end
            default:
            begin
                r.code  = CODE_NONE;
                r.value = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/jepd_front.sv
module jepd_front
    import jepd_pkg::*;
#(
    parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         in_valid,
    input  logic         command,
    input  logic [28:0]  can_id,
    input  logic [7:0]   byte0,
    input  logic [7:0]   byte1,
    input  logic [7:0]   byte2,
    input  logic [7:0]   byte3,
    input  logic [7:0]   byte4,
    input  logic [7:0]   byte5,
    input  logic [7:0]   byte6,
    input  fifo_status_t status,
    output logic         push,
    output entry_t       push_entry
);

    // compare width covers both counter and timeout register
    localparam int CW = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;

    logic [7:0]  ecu_addr_reg;
    logic [7:0]  conv_addr_reg;
    logic [15:0] timeout_reg;
    logic        link_en_reg;

    logic [TICK_COUNTER_BITS-1:0] ticks_reg, ticks_next;
    logic                         conn_reg, conn_next;

    logic [TICK_COUNTER_BITS-1:0] ticks_inc;
    logic                         conn_timed;
    logic                         frame;
    logic [15:0]                  pgn;
    logic [7:0]                   src;
    logic                         from_ecu;
    logic                         from_conv;
    kind_t                        kind;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecu_addr_reg  <= '0;
            conv_addr_reg <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            link_en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ECU_ADDR:  ecu_addr_reg  <= cfg_data[7:0];
                CFG_CONV_ADDR: conv_addr_reg <= cfg_data[7:0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                CFG_LINK_EN:   link_en_reg   <= cfg_data[0];
                default:       link_en_reg   <= link_en_reg;
            endcase
        end
    end

    // identifier split
    assign pgn       = 16'((can_id & PGN_MASK) >> 8);
    assign src       = 8'(can_id & SRC_MASK);
    assign frame     = !command && link_en_reg;
    assign from_ecu  = (src == ecu_addr_reg);
    assign from_conv = (src == conv_addr_reg);

    // tick count, timeout, then frame seen
    always_comb
    begin
        ticks_inc = ticks_reg;
        if (command && (ticks_reg != '1))
            ticks_inc = ticks_reg + 1'b1;
        conn_timed = conn_reg;
        if (CW'(ticks_inc) >= CW'(timeout_reg))
            conn_timed = 1'b0;
        ticks_next = ticks_inc;
        conn_next  = conn_timed;
        if (frame && (from_ecu || from_conv))
        begin
            ticks_next = '0;
            conn_next  = 1'b1;
        end
    end

    // classify the frame
    always_comb
    begin
        kind = KIND_NONE;
        if (frame && from_ecu)
        begin
            unique case (pgn)
                PGN_EEC2:  kind = KIND_EEC2;
                PGN_EEC1:  kind = KIND_EEC1;
                PGN_ET1:   kind = KIND_ET1;
                PGN_EFLP1: kind = KIND_EFLP1;
                PGN_LFE:   kind = KIND_LFE;
                PGN_IC1:   kind = KIND_IC1;
                default:   kind = KIND_NONE;
            endcase
        end
    end

    assign push = in_valid && !status.full;

    always_comb
    begin
        push_entry.kind      = kind;
        push_entry.connected = conn_next;
        push_entry.b0        = byte0;
        push_entry.b1        = byte1;
        push_entry.b2        = byte2;
        push_entry.b3        = byte3;
        push_entry.b4        = byte4;
        push_entry.b5        = byte5;
        push_entry.b6        = byte6;
    end

    // link state, updated per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= '0;
            conn_reg  <= 1'b0;
        end
        else if (push)
        begin
            ticks_reg <= ticks_next;
            conn_reg  <= conn_next;
        end
    end

endmodule

// File: rtl/jepd_queue.sv
module jepd_queue
    import jepd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  entry_t       push_entry,
    input  logic         pop,
    output entry_t       head,
    output fifo_status_t status
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

    entry_t        mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (cnt_reg == FULL_CNT);
    assign status.empty = (cnt_reg == '0);

endmodule

// File: rtl/jepd_back.sv
module jepd_back
    import jepd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  entry_t             head,
    input  fifo_status_t       status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         param_code,
    output logic signed [16:0] param_value,
    output logic               last,
    output logic               connected
);

    logic [1:0]         idx_reg, idx_next;
    logic               valid_reg;
    logic [3:0]         code_reg;
    logic signed [16:0] value_reg;
    logic               last_reg;
    logic               conn_reg;

    logic    load;
    logic    is_last;
    record_t rec;

    // output register takes a new record when empty or drained
    assign load    = !valid_reg || !out_stall;
    assign rec     = make_record(head, idx_reg);
    assign is_last = (idx_reg == last_index(head.kind));
    assign pop     = load && !status.empty && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load && !status.empty)
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
    end

    // record position and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                valid_reg <= !status.empty;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load && !status.empty)
        begin
            code_reg  <= rec.code;
            value_reg <= rec.value;
            last_reg  <= is_last;
            conn_reg  <= head.connected;
        end
    end

    assign out_valid   = valid_reg;
    assign param_code  = code_reg;
    assign param_value = value_reg;
    assign last        = last_reg;
    assign connected   = conn_reg;

endmodule

// File: rtl/j1939_engine_param_decoder.sv
// channel   direction  handshake            payload
// config    in         cfg_we               cfg_index, cfg_data
// input     in         in_valid / in_stall  command, can_id, byte0..byte7
// output    out        out_valid / out_stall param_code, param_value, last, connected
//
// one input transaction is taken per cycle while the two-entry queue has room
// the back end sends one record per cycle while out_stall is low: a frame of ET1
// or IC1 gives three records, every other transaction one, and the queue entry
// is popped with its final record, as the record sequencer in the back end sets
// reset clears the tick counter, the connected flag and the queue; timeout is 1000
// out_stall holds the output register; in_stall rises when the queue is full
module j1939_engine_param_decoder
    import jepd_pkg::*;
#(
    parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [28:0]        can_id,
    input  logic [7:0]         byte0,
    input  logic [7:0]         byte1,
    input  logic [7:0]         byte2,
    input  logic [7:0]         byte3,
    input  logic [7:0]         byte4,
    input  logic [7:0]         byte5,
    input  logic [7:0]         byte6,
    input  logic [7:0]         byte7,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         param_code,
    output logic signed [16:0] param_value,
    output logic               last,
    output logic               connected
);

    logic         push;
    logic         pop;
    entry_t       push_entry;
    entry_t       head;
    fifo_status_t status;
    logic         unused_byte7;

    // byte 7 carries no decoded parameter
    assign unused_byte7 = ^byte7;

    // classify and track link state
    jepd_front #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .command    (command),
        .can_id     (can_id),
        .byte0      (byte0),
        .byte1      (byte1),
        .byte2      (byte2),
        .byte3      (byte3),
        .byte4      (byte4),
        .byte5      (byte5),
        .byte6      (byte6),
        .status     (status),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue
    jepd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    // record sequencer and output register
    jepd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .status      (status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .param_code  (param_code),
        .param_value (param_value),
        .last        (last),
        .connected   (connected)
    );

    assign in_stall = status.full;

    // records before the final one are real parameters
    a_mid_record_coded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (param_code != CODE_NONE))
        else $error("non-final record without a parameter code");

    // the empty record stands alone and carries zero
    a_none_record: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (param_code == CODE_NONE)) |-> (last && (param_value == 17'sd0)))
        else $error("empty record not final or not zero");

    // remaining records of a transaction follow without a gap
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("gap inside a record run");

    // queue never pops and reports empty at once
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule
